// ===== hw/rtl/dtbp_pkg.sv =====
package dtbp_pkg;

  // Width of the position and run counters
  localparam int unsigned PosW = 32;

  // Record queue between front and back (power of two)
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  // ASCII characters of interest
  localparam logic [7:0] ChLowT = 8'h74;
  localparam logic [7:0] ChLowC = 8'h63;
  localparam logic [7:0] ChLowA = 8'h61;
  localparam logic [7:0] ChLowG = 8'h67;
  localparam logic [7:0] ChLowN = 8'h6e;
  localparam logic [7:0] ChUpT  = 8'h54;
  localparam logic [7:0] ChUpC  = 8'h43;
  localparam logic [7:0] ChUpA  = 8'h41;
  localparam logic [7:0] ChUpG  = 8'h47;
  localparam logic [7:0] ChUpN  = 8'h4e;

  // Two-bit base codes
  localparam logic [1:0] BaseT = 2'd0;
  localparam logic [1:0] BaseC = 2'd1;
  localparam logic [1:0] BaseA = 2'd2;
  localparam logic [1:0] BaseG = 2'd3;

  // Record kinds; also the bit positions in a bundle's record mask
  typedef enum logic [1:0] {
    RecByte  = 2'd0,
    RecNRun  = 2'd1,
    RecUpper = 2'd2,
    RecEnd   = 2'd3
  } rec_kind_e;

  localparam int unsigned NumKinds = 4;

  // All records caused by one character
  typedef struct packed {
    logic [NumKinds-1:0] mask;
    logic [7:0]          byte_val;
    logic [31:0]         n_start;
    logic [31:0]         n_len;
    logic [31:0]         u_start;
    logic [31:0]         u_len;
    logic [31:0]         end_len;
    logic                end_ovf;
  } rec_bundle_t;

  function automatic logic [1:0] base_code(input logic [7:0] ch);
    logic [1:0] code;
    code = BaseT;
    if (ch == ChLowC || ch == ChUpC) code = BaseC;
    else if (ch == ChLowA || ch == ChUpA) code = BaseA;
    else if (ch == ChLowG || ch == ChUpG) code = BaseG;
    return code;
  endfunction

  // Saturating increment at the counter's all-ones value
  function automatic logic [PosW-1:0] sat_inc(input logic [PosW-1:0] v);
    logic [PosW-1:0] r;
    r = (v == '1) ? v : v + PosW'(1);
    return r;
  endfunction

  // Clamp a counter value into a 32-bit field
  function automatic logic [31:0] sat32(input logic [PosW-1:0] v);
    logic [PosW+31:0] ext;
    logic [31:0]      r;
    ext = {32'd0, v};
    if (ext[PosW+31:32] != '0) r = '1;
    else r = ext[31:0];
    return r;
  endfunction

endpackage

// ===== hw/rtl/dna_two_bit_packer_unit.sv =====
// Path: a character's records pass the queue write, the bundle load and the output
// register in that order; further records follow one a cycle while the receiver is ready.
// Throughput: one character per cycle while each yields at most one record and the
// receiver is ready; the back end drains one record per cycle unless the receiver stalls,
// so characters with several records back up the four-entry queue and input ready drops while it is full.
// Reset: asynchronous active low; counters, packer and queue clear, no sweep.
module dna_two_bit_packer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        final_char_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  record_kind_o,
  output logic [7:0]  packed_byte_o,
  output logic [31:0] run_start_o,
  output logic [31:0] run_length_o,
  output logic        length_overflow_o,
  output logic        final_record_o
);
  import dtbp_pkg::*;

  logic        push, full, pop, empty;
  rec_bundle_t push_data, pop_data;

  // Classify characters, track runs, build record bundles
  dtbp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_code_i  (char_code_i),
    .final_char_i (final_char_i),
    .full_i       (full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  // Decoupling queue
  dtbp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  // Serialize bundles into output records
  dtbp_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .empty_i           (empty),
    .pop_data_i        (pop_data),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .record_kind_o     (record_kind_o),
    .packed_byte_o     (packed_byte_o),
    .run_start_o       (run_start_o),
    .run_length_o      (run_length_o),
    .length_overflow_o (length_overflow_o),
    .final_record_o    (final_record_o)
  );

endmodule

// ===== hw/rtl/dtbp_front.sv =====
module dtbp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           char_code_i,
  input  logic                 final_char_i,
  input  logic                 full_i,
  output logic                 push_o,
  output dtbp_pkg::rec_bundle_t push_data_o
);
  import dtbp_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] nst_q, nst_d, nlen_q, nlen_d;
  logic [PosW-1:0] ust_q, ust_d, ulen_q, ulen_d;
  logic [7:0]      acc_q, acc_d;
  logic            ovf_q, ovf_d;

  logic            accept;
  logic [1:0]      slot;
  logic [2:0]      shamt;
  logic [7:0]      acc_fill;
  logic            is_n, is_up;
  logic            emit_byte, n_close, u_close;
  logic [PosW-1:0] n_len_new, n_st_new, u_len_new, u_st_new;
  logic            pos_sat;
  logic [PosW-1:0] pos_new;
  logic            ovf_new;
  rec_bundle_t     bundle;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Byte packing: slot s lands at bits 2*(3-s)+1 .. 2*(3-s)
  assign slot      = pos_q[1:0];
  assign shamt     = {~slot, 1'b0};
  assign acc_fill  = acc_q | ({6'd0, base_code(char_code_i)} << shamt);
  assign emit_byte = (slot == 2'd3) || final_char_i;

  // Character classes
  assign is_n  = (char_code_i == ChLowN) || (char_code_i == ChUpN);
  assign is_up = (char_code_i == ChUpT) || (char_code_i == ChUpC) ||
                 (char_code_i == ChUpA) || (char_code_i == ChUpG) ||
                 (char_code_i == ChUpN);

  // Run tracking, including the current character
  assign n_len_new = is_n ? sat_inc(nlen_q) : nlen_q;
  assign n_st_new  = (is_n && nlen_q == '0) ? pos_q : nst_q;
  assign n_close   = (n_len_new != '0) && (!is_n || final_char_i);
  assign u_len_new = is_up ? sat_inc(ulen_q) : ulen_q;
  assign u_st_new  = (is_up && ulen_q == '0) ? pos_q : ust_q;
  assign u_close   = (u_len_new != '0) && (!is_up || final_char_i);

  // Position counter saturates and flags overflow
  assign pos_sat = (pos_q == '1);
  assign pos_new = pos_sat ? pos_q : pos_q + PosW'(1);
  assign ovf_new = ovf_q | pos_sat;

  // Records of this character
  always_comb begin
    bundle               = '0;
    bundle.mask[RecByte]  = emit_byte;
    bundle.mask[RecNRun]  = n_close;
    bundle.mask[RecUpper] = u_close;
    bundle.mask[RecEnd]   = final_char_i;
    bundle.byte_val      = acc_fill;
    bundle.n_start       = sat32(n_st_new);
    bundle.n_len         = sat32(n_len_new);
    bundle.u_start       = sat32(u_st_new);
    bundle.u_len         = sat32(u_len_new);
    bundle.end_len       = sat32(pos_new);
    bundle.end_ovf       = ovf_new;
  end

  assign push_o      = accept && (bundle.mask != '0);
  assign push_data_o = bundle;

  // Next state; the final character returns everything to reset values
  always_comb begin
    pos_d  = pos_q;
    nst_d  = nst_q;
    nlen_d = nlen_q;
    ust_d  = ust_q;
    ulen_d = ulen_q;
    acc_d  = acc_q;
    ovf_d  = ovf_q;
    if (accept) begin
      if (final_char_i) begin
        pos_d  = '0;
        nst_d  = '0;
        nlen_d = '0;
        ust_d  = '0;
        ulen_d = '0;
        acc_d  = '0;
        ovf_d  = 1'b0;
      end else begin
        pos_d  = pos_new;
        nst_d  = n_st_new;
        nlen_d = n_close ? '0 : n_len_new;
        ust_d  = u_st_new;
        ulen_d = u_close ? '0 : u_len_new;
        acc_d  = emit_byte ? 8'd0 : acc_fill;
        ovf_d  = ovf_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      nst_q  <= '0;
      nlen_q <= '0;
      ust_q  <= '0;
      ulen_q <= '0;
      acc_q  <= '0;
      ovf_q  <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      nst_q  <= nst_d;
      nlen_q <= nlen_d;
      ust_q  <= ust_d;
      ulen_q <= ulen_d;
      acc_q  <= acc_d;
      ovf_q  <= ovf_d;
    end
  end

endmodule

// ===== hw/rtl/dtbp_queue.sv =====
module dtbp_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  dtbp_pkg::rec_bundle_t push_data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output dtbp_pkg::rec_bundle_t pop_data_o,
  output logic                  empty_o
);
  import dtbp_pkg::*;

  rec_bundle_t      mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]   count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == (QPtrW+1)'(QDepth));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) count_d = count_q + (QPtrW+1)'(1);
    else if (!do_push && do_pop) count_d = count_q - (QPtrW+1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QPtrW+1)'(QDepth)) else $error("queue count out of range");

endmodule

// ===== hw/rtl/dtbp_back.sv =====
module dtbp_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  empty_i,
  input  dtbp_pkg::rec_bundle_t pop_data_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            record_kind_o,
  output logic [7:0]            packed_byte_o,
  output logic [31:0]           run_start_o,
  output logic [31:0]           run_length_o,
  output logic                  length_overflow_o,
  output logic                  final_record_o
);
  import dtbp_pkg::*;

  rec_bundle_t         pend_q, pend_d;
  logic [NumKinds-1:0] mask_rem;
  logic                adv, have_rec;
  rec_kind_e           pick;

  logic        valid_q, valid_d;
  rec_kind_e   kind_q, kind_d;
  logic [7:0]  byte_q, byte_d;
  logic [31:0] start_q, start_d, len_q, len_d;
  logic        ovf_q, ovf_d, fin_q, fin_d;

  // Output register frees up when empty or taken
  assign adv      = !valid_q || out_ready_i;
  assign have_rec = (pend_q.mask != '0);

  // Lowest pending kind goes first
  always_comb begin
    priority if (pend_q.mask[RecByte]) pick = RecByte;
    else if (pend_q.mask[RecNRun]) pick = RecNRun;
    else if (pend_q.mask[RecUpper]) pick = RecUpper;
    else pick = RecEnd;
  end

  always_comb begin
    mask_rem = pend_q.mask;
    if (adv && have_rec) mask_rem[pick] = 1'b0;
  end

  // Refill the held bundle when it runs dry
  assign pop_o = (mask_rem == '0) && !empty_i;

  always_comb begin
    pend_d      = pend_q;
    pend_d.mask = mask_rem;
    if (pop_o) pend_d = pop_data_i;
  end

  // Output record fields
  always_comb begin
    valid_d = valid_q;
    kind_d  = kind_q;
    byte_d  = byte_q;
    start_d = start_q;
    len_d   = len_q;
    ovf_d   = ovf_q;
    fin_d   = fin_q;
    if (adv) begin
      valid_d = have_rec;
      kind_d  = pick;
      byte_d  = 8'd0;
      start_d = 32'd0;
      len_d   = 32'd0;
      ovf_d   = 1'b0;
      fin_d   = 1'b0;
      unique case (pick)
        RecByte: byte_d = pend_q.byte_val;
        RecNRun: begin
          start_d = pend_q.n_start;
          len_d   = pend_q.n_len;
        end
        RecUpper: begin
          start_d = pend_q.u_start;
          len_d   = pend_q.u_len;
        end
        RecEnd: begin
          len_d = pend_q.end_len;
          ovf_d = pend_q.end_ovf;
          fin_d = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      pend_q  <= pend_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    byte_q  <= byte_d;
    start_q <= start_d;
    len_q   <= len_d;
    ovf_q   <= ovf_d;
    fin_q   <= fin_d;
  end

  assign out_valid_o       = valid_q;
  assign record_kind_o     = kind_q;
  assign packed_byte_o     = byte_q;
  assign run_start_o       = start_q;
  assign run_length_o      = len_q;
  assign length_overflow_o = ovf_q;
  assign final_record_o    = fin_q;

  a_final_is_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && fin_q |-> kind_q == RecEnd) else $error("final flag on non-end record");

  a_byte_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && kind_q == RecByte |-> len_q == 32'd0 && start_q == 32'd0 && !fin_q)
    else $error("packed byte record carries run fields");

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dtbp_pkg::*;

  localparam int unsigned StallLimit = 3000;  // cycles without any transfer
  localparam int unsigned HoldCycles = 300;   // long receiver hold-off
  localparam int unsigned TailCycles = 24;    // settle time after the last record

  // One character of a sequence
  typedef struct {
    logic [7:0] ch;
    logic       fin;
  } seq_char_t;

  // One expected output record
  typedef struct {
    rec_kind_e   kind;
    logic [7:0]  byte_val;
    logic [31:0] start;
    logic [31:0] len;
    logic        ovf;
    logic        fin;
  } out_rec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  char_code_i = 8'd0;
  logic        final_char_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  record_kind_o;
  logic [7:0]  packed_byte_o;
  logic [31:0] run_start_o;
  logic [31:0] run_length_o;
  logic        length_overflow_o;
  logic        final_record_o;

  seq_char_t   pending_chars[$];
  out_rec_t    due_records[$];
  int unsigned err_cnt = 0;
  int unsigned send_idle_pct = 30;
  int unsigned recv_idle_pct = 88;
  int unsigned hold_reqs = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  out_rec_t    got_exp;

  // Shadow state of the packer
  logic [PosW-1:0] pos_cnt;
  logic [7:0]      acc_byte;
  logic [PosW-1:0] nrun_start;
  logic [PosW-1:0] nrun_len;
  logic [PosW-1:0] urun_start;
  logic [PosW-1:0] urun_len;
  logic            ovf_seen;

  dna_two_bit_packer_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .char_code_i      (char_code_i),
    .final_char_i     (final_char_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .record_kind_o    (record_kind_o),
    .packed_byte_o    (packed_byte_o),
    .run_start_o      (run_start_o),
    .run_length_o     (run_length_o),
    .length_overflow_o(length_overflow_o),
    .final_record_o   (final_record_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Clamp a counter into a 32-bit output field
  function automatic logic [31:0] clamp32(input logic [PosW-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

  function automatic logic [PosW-1:0] inc_sat(input logic [PosW-1:0] v);
    return (v == '1) ? v : v + PosW'(1);
  endfunction

  task automatic clear_shadow();
    pos_cnt    = '0;
    acc_byte   = '0;
    nrun_start = '0;
    nrun_len   = '0;
    urun_start = '0;
    urun_len   = '0;
    ovf_seen   = 1'b0;
  endtask

  task automatic queue_record(input rec_kind_e kind, input logic [7:0] b,
                              input logic [PosW-1:0] start, input logic [PosW-1:0] len,
                              input logic ovf, input logic fin);
    out_rec_t r;
    r.kind     = kind;
    r.byte_val = b;
    r.start    = clamp32(start);
    r.len      = clamp32(len);
    r.ovf      = ovf;
    r.fin      = fin;
    due_records = {due_records, r};
  endtask

  // Work out the records that one transferred character causes
  task automatic pack_char(input logic [7:0] ch, input logic fin);
    logic [PosW-1:0] idx;
    logic [1:0]      slot;
    logic [1:0]      code;
    logic            is_n;
    logic            is_up;
    idx  = pos_cnt;
    slot = pos_cnt[1:0];
    code = BaseT;
    if (ch == ChLowC || ch == ChUpC) code = BaseC;
    else if (ch == ChLowA || ch == ChUpA) code = BaseA;
    else if (ch == ChLowG || ch == ChUpG) code = BaseG;

    acc_byte = acc_byte | (8'(code) << (6 - 2 * int'(slot)));
    if (slot == 2'd3 || fin) begin
      queue_record(RecByte, acc_byte, '0, '0, 1'b0, 1'b0);
      acc_byte = '0;
    end

    is_n  = (ch == ChLowN || ch == ChUpN);
    is_up = (ch == ChUpT || ch == ChUpC || ch == ChUpA || ch == ChUpG || ch == ChUpN);
    if (is_n) begin
      if (nrun_len == '0) nrun_start = idx;
      nrun_len = inc_sat(nrun_len);
    end
    if (is_up) begin
      if (urun_len == '0) urun_start = idx;
      urun_len = inc_sat(urun_len);
    end

    // runs close on a non-member or at the last character
    if (nrun_len != '0 && (!is_n || fin)) begin
      queue_record(RecNRun, 8'd0, nrun_start, nrun_len, 1'b0, 1'b0);
      nrun_len = '0;
    end
    if (urun_len != '0 && (!is_up || fin)) begin
      queue_record(RecUpper, 8'd0, urun_start, urun_len, 1'b0, 1'b0);
      urun_len = '0;
    end

    if (pos_cnt != '1) pos_cnt = pos_cnt + PosW'(1);
    else ovf_seen = 1'b1;

    if (fin) begin
      queue_record(RecEnd, 8'd0, '0, pos_cnt, ovf_seen, 1'b1);
      clear_shadow();
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    err_cnt++;
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // Driver: offers the next pending character, idling at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      char_code_i  <= 8'd0;
      final_char_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) pack_char(char_code_i, final_char_i);
      if (!in_valid_i || in_ready_o) begin
        if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i   <= 1'b1;
          char_code_i  <= pending_chars[0].ch;
          final_char_i <= pending_chars[0].fin;
          void'(pending_chars.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each record transfer, drives ready with stalls and hold-offs
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (due_records.size() == 0) begin
          flag_mismatch("unexpected record kind", 32'(record_kind_o), 32'hFFFF_FFFF);
        end else begin
          got_exp = due_records.pop_front();
          if (record_kind_o !== got_exp.kind)
            flag_mismatch("record_kind", 32'(record_kind_o), 32'(got_exp.kind));
          if (packed_byte_o !== got_exp.byte_val)
            flag_mismatch("packed_byte", 32'(packed_byte_o), 32'(got_exp.byte_val));
          if (run_start_o !== got_exp.start)
            flag_mismatch("run_start", run_start_o, got_exp.start);
          if (run_length_o !== got_exp.len)
            flag_mismatch("run_length", run_length_o, got_exp.len);
          if (length_overflow_o !== got_exp.ovf)
            flag_mismatch("length_overflow", 32'(length_overflow_o), 32'(got_exp.ovf));
          if (final_record_o !== got_exp.fin)
            flag_mismatch("final_record", 32'(final_record_o), 32'(got_exp.fin));
        end
      end
      if (hold_served != hold_reqs) begin
        hold_served++;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles", $realtime, quiet_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic add_char(input logic [7:0] ch, input logic fin);
    seq_char_t c;
    c.ch  = ch;
    c.fin = fin;
    pending_chars = {pending_chars, c};
  endtask

  // Pick a character for a segment of a given flavor
  function automatic logic [7:0] pick_char(input int unsigned flavor);
    logic [7:0] ups[5];
    logic [7:0] lows[5];
    ups  = '{ChUpT, ChUpC, ChUpA, ChUpG, ChUpN};
    lows = '{ChLowT, ChLowC, ChLowA, ChLowG, ChLowN};
    case (flavor)
      0, 1, 2: return ($urandom_range(1) != 0) ? ChUpN : ChLowN;
      3, 4, 5: return ups[$urandom_range(3)];
      6, 7:    return lows[$urandom_range(3)];
      8:       return ($urandom_range(1) != 0) ? ups[$urandom_range(4)] : lows[$urandom_range(4)];
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // One random sequence built from runs; returns its length
  task automatic add_sequence(output int unsigned n);
    int unsigned total;
    int unsigned seg_left;
    int unsigned flavor;
    total    = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    seg_left = 0;
    flavor   = 0;
    for (int unsigned i = 0; i < total; i++) begin
      if (seg_left == 0) begin
        flavor   = $urandom_range(9);
        seg_left = $urandom_range(1, 6);
      end
      seg_left--;
      add_char(pick_char(flavor), (i == total - 1));
    end
    n = total;
  endtask

  task automatic add_random(input int unsigned target);
    int unsigned count;
    int unsigned n;
    count = 0;
    while (count < target) begin
      add_sequence(n);
      count += n;
    end
  endtask

  task automatic wait_drained();
    while (pending_chars.size() != 0 || in_valid_i || due_records.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    clear_shadow();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: single N ending the sequence (all four kinds at once)
    add_char(ChUpN, 1'b1);
    // full byte that is also the final char
    add_char(ChUpA, 1'b0); add_char(ChUpC, 1'b0);
    add_char(ChUpG, 1'b0); add_char(ChUpT, 1'b1);
    // lowercase bases, then an N run closed by the final char
    add_char(ChLowT, 1'b0); add_char(ChLowC, 1'b0); add_char(ChLowA, 1'b0);
    add_char(ChLowG, 1'b0); add_char(ChLowN, 1'b1);
    // extreme character codes
    add_char(8'h00, 1'b0); add_char(8'hFF, 1'b0); add_char(ChUpG, 1'b1);
    // mixed-case N run closed by G, uppercase run split by lowercase n
    add_char(ChLowN, 1'b0); add_char(ChUpN, 1'b0); add_char(ChLowN, 1'b0);
    add_char(ChUpG, 1'b0); add_char(ChUpA, 1'b1);
    // uppercase run broken by a lowercase base, partial last byte
    add_char(ChUpT, 1'b0); add_char(ChUpC, 1'b0); add_char(ChLowA, 1'b0);
    add_char(ChUpG, 1'b0); add_char(ChUpA, 1'b1);
    wait_drained();

    // Sender idles lightly, receiver heavily
    add_random(90);
    wait_drained();

    // Receiver holds off while the sender keeps offering
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_reqs++;
    add_random(40);
    wait_drained();

    // Sender idles heavily, receiver lightly
    send_idle_pct = 88;
    recv_idle_pct = 30;
    add_random(90);
    wait_drained();

    // No idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random(60);
    wait_drained();

    repeat (TailCycles) @(negedge clk_i);
    if (err_cnt == 0 && due_records.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
